### design/dfd_pkg.sv
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared types and constants for the diagnostic frame deframer: result kind
// and status codes, the minimum frame length and the header byte positions.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;

  // Smallest legal frame: address, command, length, two checksum bytes
  localparam logic [ByteW-1:0] MinFrameLen = 8'd5;

  // Frame positions of the address, command and length bytes
  localparam logic [ByteW-1:0] PosAddr = 8'd0;
  localparam logic [ByteW-1:0] PosCmd  = 8'd1;
  localparam logic [ByteW-1:0] PosLen  = 8'd2;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_ABORT   = 2'd3
  } status_e;

  // One result transaction
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    kind_e            kind;
    status_e          status;
    logic             last;
  } result_t;

endpackage

### design/dfd_if.sv
// ----------------------------------------------------------------------------
// dfd_if
// Valid/ready channels of the deframer: received line bytes in, command,
// data and end-of-frame results out.
// ----------------------------------------------------------------------------
interface dfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_idle;

  modport source (output valid, output rx_byte, output line_idle, input ready);
  modport sink   (input valid, input rx_byte, input line_idle, output ready);
endinterface

interface dfd_out_if;
  logic           valid;
  logic           ready;
  logic [7:0]     out_byte;
  dfd_pkg::kind_e   kind;
  dfd_pkg::status_e status;
  logic           last;

  modport source (output valid, output out_byte, output kind, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input status,
                  input last, output ready);
endinterface

### design/diag_frame_deframer_sum16.sv
// ----------------------------------------------------------------------------
// diag_frame_deframer_sum16
// Streaming deframer for length-prefixed diagnostic frames with a 16-bit
// additive checksum. Passes the command and data bytes through and closes
// each frame with one end-of-frame status transaction.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | role
//  --------+-----+----------------------------------+---------------------------
//  rx_i    | in  | rx_byte[7:0], line_idle          | one line byte per transaction
//  res_o   | out | out_byte[7:0], kind, status, last| command, data or end result
//
//  One byte is accepted every cycle while res_o does not stall; each byte passes
//  through an input register, then the frame state update and the result
//  register. Bytes that give no result (address, valid length, low checksum,
//  idle while hunting) leave nothing in the result register.
//  Reset (rst_ni low, asynchronous) returns the block to hunting with all
//  frame state cleared. A stall on res_o holds the input register when its
//  byte gives a result, and rx_i ready drops only while both registers are occupied.
// ----------------------------------------------------------------------------
module diag_frame_deframer_sum16 (
  input  logic   clk_i,
  input  logic   rst_ni,
  dfd_in_if.sink    rx_i,
  dfd_out_if.source res_o
);
  import dfd_pkg::*;

  // Input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_idle_q;

  // Frame state
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] sum_lo_q, sum_lo_d;

  // Result register
  logic    res_vld_q;
  result_t res_q, res_d;

  logic emit;
  logic res_free;
  logic advance;
  logic [ByteW:0] pos_plus2;
  logic [SumW-1:0] sum_add;

  assign res_free  = !res_vld_q || res_o.ready;
  assign advance   = in_vld_q && (res_free || !emit);
  assign rx_i.ready = !in_vld_q || advance;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
      in_idle_q <= rx_i.line_idle;
    end
  end

  assign pos_plus2 = {1'b0, cnt_q} + 9'd2;
  assign sum_add   = sum_q + {{(SumW-ByteW){1'b0}}, in_byte_q};

  // Advance the frame state and build the result
  always_comb begin
    cnt_d    = cnt_q;
    len_d    = len_q;
    sum_d    = sum_q;
    sum_lo_d = sum_lo_q;
    emit     = 1'b0;
    res_d    = '{out_byte: '0, kind: KIND_END, status: ST_OK, last: 1'b1};

    if (in_idle_q) begin
      // Drop a partial frame
      if (cnt_q != PosAddr) begin
        cnt_d        = '0;
        len_d        = '0;
        sum_d        = '0;
        sum_lo_d     = '0;
        emit         = 1'b1;
        res_d.status = ST_ABORT;
      end
    end else if (cnt_q == PosAddr) begin
      sum_d = {{(SumW-ByteW){1'b0}}, in_byte_q};
      cnt_d = PosCmd;
    end else if (cnt_q == PosCmd) begin
      sum_d          = sum_add;
      cnt_d          = PosLen;
      emit           = 1'b1;
      res_d.out_byte = in_byte_q;
      res_d.kind     = KIND_CMD;
      res_d.last     = 1'b0;
    end else if (cnt_q == PosLen) begin
      if (in_byte_q < MinFrameLen) begin
        cnt_d        = '0;
        len_d        = '0;
        sum_d        = '0;
        sum_lo_d     = '0;
        emit         = 1'b1;
        res_d.status = ST_BAD_LEN;
      end else begin
        len_d = in_byte_q;
        sum_d = sum_add;
        cnt_d = cnt_q + 8'd1;
      end
    end else if (len_q >= MinFrameLen && pos_plus2 < {1'b0, len_q}) begin
      // Data byte
      sum_d          = sum_add;
      cnt_d          = cnt_q + 8'd1;
      emit           = 1'b1;
      res_d.out_byte = in_byte_q;
      res_d.kind     = KIND_DATA;
      res_d.last     = 1'b0;
    end else if (len_q >= MinFrameLen && pos_plus2 == {1'b0, len_q}) begin
      // Low checksum byte
      sum_lo_d = in_byte_q;
      cnt_d    = cnt_q + 8'd1;
    end else begin
      // High checksum byte: close the frame
      cnt_d    = '0;
      len_d    = '0;
      sum_d    = '0;
      sum_lo_d = '0;
      emit     = 1'b1;
      res_d.status = (sum_lo_q == sum_q[ByteW-1:0] && in_byte_q == sum_q[SumW-1:ByteW])
                     ? ST_OK : ST_BAD_SUM;
    end
  end

  // Hold frame state until the byte is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      sum_lo_q <= '0;
    end else if (advance) begin
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      sum_lo_q <= sum_lo_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && advance && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid    = res_vld_q;
  assign res_o.out_byte = res_q.out_byte;
  assign res_o.kind     = res_q.kind;
  assign res_o.status   = res_q.status;
  assign res_o.last     = res_q.last;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the diagnostic frame deframer. Drives line bytes over the rx
// channel, predicts the command, data and end-of-frame transactions with its
// own frame tracker and checks every result transaction against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dfd_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;

  logic clk_i;
  logic rst_ni;

  dfd_in_if  rx_if ();
  dfd_out_if res_if ();

  diag_frame_deframer_sum16 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Frame tracker state, mirrors the block after each accepted byte
  logic [7:0]  frm_count;
  logic [7:0]  frm_len;
  logic [15:0] frm_sum;
  logic [7:0]  sum_lo;

  result_t pending_results[$];
  int      fail_count  = 0;
  int      cycle_count = 0;
  int      bytes_sent  = 0;
  bit      gaps_on     = 1'b0;
  bit      stalls_on   = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void restart_hunt();
    frm_count = PosAddr;
    frm_len   = 8'd0;
    frm_sum   = 16'd0;
    sum_lo    = 8'd0;
  endfunction

  // Advance the frame tracker by one line byte and queue any result it gives
  function automatic void deframe_byte(input logic [7:0] b, input logic idle);
    result_t r;
    int      pos;
    int      len;
    r.out_byte = 8'd0;
    r.kind     = KIND_END;
    r.status   = ST_OK;
    r.last     = 1'b1;
    pos = int'(frm_count);
    len = int'(frm_len);
    if (idle) begin
      if (frm_count != PosAddr) begin
        r.status = ST_ABORT;
        pending_results.push_back(r);
        restart_hunt();
      end
    end else if (frm_count == PosAddr) begin
      frm_sum   = 16'(b);
      frm_count = PosCmd;
    end else if (frm_count == PosCmd) begin
      frm_sum    = frm_sum + 16'(b);
      frm_count  = PosLen;
      r.out_byte = b;
      r.kind     = KIND_CMD;
      r.last     = 1'b0;
      pending_results.push_back(r);
    end else if (frm_count == PosLen) begin
      if (b < MinFrameLen) begin
        r.status = ST_BAD_LEN;
        pending_results.push_back(r);
        restart_hunt();
      end else begin
        frm_len   = b;
        frm_sum   = frm_sum + 16'(b);
        frm_count = PosLen + 8'd1;
      end
    end else if (pos + 2 < len) begin
      frm_sum    = frm_sum + 16'(b);
      frm_count  = frm_count + 8'd1;
      r.out_byte = b;
      r.kind     = KIND_DATA;
      r.last     = 1'b0;
      pending_results.push_back(r);
    end else if (pos + 2 == len) begin
      sum_lo    = b;
      frm_count = frm_count + 8'd1;
    end else begin
      r.status = (sum_lo == frm_sum[7:0] && b == frm_sum[15:8]) ? ST_OK : ST_BAD_SUM;
      pending_results.push_back(r);
      restart_hunt();
    end
  endfunction

  // Predict on accepted input transactions, then check result transactions
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      restart_hunt();
    end else begin
      if (rx_if.valid && rx_if.ready) deframe_byte(rx_if.rx_byte, rx_if.line_idle);
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result byte=%h kind=%0d status=%0d last=%b", $realtime,
                   res_if.out_byte, res_if.kind, res_if.status, res_if.last);
        end else begin
          want = pending_results.pop_front();
          if (res_if.out_byte !== want.out_byte || res_if.kind !== want.kind ||
              res_if.status !== want.status || res_if.last !== want.last) begin
            fail_count++;
            $display("%0t: mismatch expected byte=%h kind=%0d status=%0d last=%b", $realtime,
                     want.out_byte, want.kind, want.status, want.last);
            $display("%0t:          actual   byte=%h kind=%0d status=%0d last=%b", $realtime,
                     res_if.out_byte, res_if.kind, res_if.status, res_if.last);
          end
        end
      end
    end
  end

  // Stall the result channel at random
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 99) < 25) stall_left = random_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one line byte; valid is left high so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b, input logic idle);
    int gap;
    gap = gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid     <= 1'b1;
    rx_if.rx_byte   <= b;
    rx_if.line_idle <= idle;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Build a frame and send it; sum_fault 1 spoils the low checksum byte,
  // 2 the high one; cut_at >= 0 stops after that many bytes with an idle
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len, input int sum_fault, input int cut_at);
    logic [7:0]  frame_q[$];
    logic [15:0] sum;
    int          n;
    frame_q = {addr, cmd, len};
    if (len >= MinFrameLen) begin
      for (int i = 3; i < int'(len) - 2; i++) frame_q.push_back(8'($urandom));
      sum = 16'd0;
      foreach (frame_q[i]) sum = sum + 16'(frame_q[i]);
      if (sum_fault == 1) sum[7:0] = sum[7:0] ^ (8'd1 << $urandom_range(0, 7));
      if (sum_fault == 2) sum[15:8] = sum[15:8] ^ (8'd1 << $urandom_range(0, 7));
      frame_q.push_back(sum[7:0]);
      frame_q.push_back(sum[15:8]);
    end
    n = (cut_at >= 0 && cut_at < frame_q.size()) ? cut_at : frame_q.size();
    for (int i = 0; i < n; i++) send_byte(frame_q[i], 1'b0);
    if (n < frame_q.size()) send_byte(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] random_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) return 8'd255;
    if (p < 10) return 8'($urandom_range(21, 254));
    return 8'($urandom_range(5, 20));
  endfunction

  // Edge cases: minimal frames, short lengths, bad checksums, idle handling
  task automatic test_directed_cases();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_frame(8'h00, 8'h00, MinFrameLen, 0, -1);
    send_frame(8'hff, 8'hff, 8'd4, 0, -1);
    send_frame(8'h5a, 8'ha5, 8'd0, 0, -1);
    send_frame(8'hff, 8'h80, 8'd6, 2, -1);
    send_byte(8'hff, 1'b1);
    send_frame(8'h12, 8'h34, 8'd6, 0, 1);
    drain_results();
  endtask

  // Well-formed frames with random content, mixed with faults and noise
  task automatic test_random_frames(input int n_bytes);
    int stop_at;
    int p;
    logic [7:0] len;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    stop_at   = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      p   = $urandom_range(0, 99);
      len = random_len();
      if (p < 70) begin
        send_frame(8'($urandom), 8'($urandom), len,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, -1);
      end else if (p < 80) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)), 0, -1);
      end else if (p < 90) begin
        send_frame(8'($urandom), 8'($urandom), len, 0, $urandom_range(1, int'(len) - 1));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        send_byte(8'($urandom), 1'b1);
      end
    end
    drain_results();
  endtask

  // Full rate on both sides
  task automatic test_back_to_back(input int n_bytes);
    int stop_at;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    stop_at   = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(5, 16)),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0, -1);
    end
    drain_results();
  endtask

  // Let the block run empty between frames
  task automatic test_drain_pause();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (4) begin
      send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(5, 12)), 0, -1);
      drain_results();
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          <= 1'b0;
    rx_if.valid     <= 1'b0;
    rx_if.rx_byte   <= 8'h00;
    rx_if.line_idle <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_frames(1000);
    test_back_to_back(300);
    test_drain_pause();
    test_random_frames(100);
    drain_results();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
design/dfd_pkg.sv
design/dfd_if.sv
design/diag_frame_deframer_sum16.sv
sim/tb_top.sv
